### hw/rtl/uart_idle_gap_frame_receiver_assert.svh
// Assertion macros used by the checker file of the idle-gap frame receiver.
`ifndef UART_IDLE_GAP_FRAME_RECEIVER_ASSERT_SVH
`define UART_IDLE_GAP_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define UIGF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uigf assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define UIGF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uigf assertion failed");

`endif

### hw/rtl/uigf_pkg.sv
// Types, constants and helpers of the idle-gap UART frame receiver.
package uigf_pkg;

    // Frame buffer geometry
    localparam int BUFFER_DEPTH = 512;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

    // Field widths of the channels
    localparam int MODE_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 9;
    localparam int LIMIT_W  = 16;
    localparam int STATE_W  = 2;
    localparam int LEN_W    = 10;
    localparam int THR_W    = 16;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd20;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Event codes
    localparam logic [MODE_W-1:0] MODE_BYTE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TAKE = 2'd3;

    // Reported phase codes
    localparam logic [STATE_W-1:0] RX_STATE_IDLE      = 2'd0;
    localparam logic [STATE_W-1:0] RX_STATE_RECEIVING = 2'd1;
    localparam logic [STATE_W-1:0] RX_STATE_RECEIVED  = 2'd2;

    // Receive phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE      = 3'b001,
        PH_RECEIVING = 3'b010,
        PH_RECEIVED  = 3'b100
    } phase_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [BYTE_W-1:0]  rx_byte;
        logic [INDEX_W-1:0] read_index;
        logic [LIMIT_W-1:0] read_limit;
    } in_item_t;

    typedef struct packed {
        logic [STATE_W-1:0] rx_state;
        logic [LEN_W-1:0]   frame_length;
        logic [BYTE_W-1:0]  read_data;
        logic [LEN_W-1:0]   taken_length;
        logic               overflow;
    } out_item_t;

    // Classified command held in the queue
    typedef struct packed {
        logic               is_byte;
        logic               is_tick;
        logic               is_read;
        logic               is_take;
        logic [BYTE_W-1:0]  rx_byte;
        logic [INDEX_W-1:0] read_index;
        logic [LIMIT_W-1:0] read_limit;
    } cmd_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    function automatic logic [STATE_W-1:0] phase_code(input phase_t ph);
        logic [STATE_W-1:0] code;
        unique case (ph)
            PH_RECEIVING: code = RX_STATE_RECEIVING;
            PH_RECEIVED:  code = RX_STATE_RECEIVED;
            default:      code = RX_STATE_IDLE;
        endcase
        return code;
    endfunction

endpackage

### hw/rtl/uigf_front.sv
// Front end: takes input items, classifies the event and feeds the command queue.
module uigf_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  uigf_pkg::in_item_t   item,
    output logic                 busy,
    input  uigf_pkg::queue_stat_t q_stat,
    output logic                 push,
    output uigf_pkg::cmd_t       push_cmd
);
    import uigf_pkg::*;

    logic   front_valid_reg, front_valid_next;
    cmd_t   front_cmd_reg, front_cmd_next;
    cmd_t   decoded;
    logic   accept;

    // Event decode
    always_comb
    begin
        decoded            = '0;
        decoded.rx_byte    = item.rx_byte;
        decoded.read_index = item.read_index;
        decoded.read_limit = item.read_limit;
        unique case (item.mode)
            MODE_BYTE: decoded.is_byte = 1'b1;
            MODE_TICK: decoded.is_tick = 1'b1;
            MODE_READ: decoded.is_read = 1'b1;
            MODE_TAKE: decoded.is_take = 1'b1;
            default:   decoded.is_take = 1'b1;
        endcase
    end

    // Holding stage handshake
    assign busy     = front_valid_reg && q_stat.full;
    assign accept   = start && !busy;
    assign push     = front_valid_reg && !q_stat.full;
    assign push_cmd = front_cmd_reg;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        front_cmd_next   = front_cmd_reg;
        if (push)
        begin
            front_valid_next = 1'b0;
        end
        if (accept)
        begin
            front_valid_next = 1'b1;
            front_cmd_next   = decoded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_cmd_reg <= front_cmd_next;
    end

endmodule

### hw/rtl/uigf_queue.sv
// Short command queue decoupling the front end from the executing back end.
module uigf_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  uigf_pkg::cmd_t        push_cmd,
    input  logic                  pop,
    output uigf_pkg::cmd_t        head_cmd,
    output uigf_pkg::queue_stat_t q_stat
);
    import uigf_pkg::*;

    cmd_t              slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head_cmd     = slots_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### hw/rtl/uigf_back.sv
// Back end: executes commands on the frame buffer and phase state, drives results.
module uigf_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  uigf_pkg::queue_stat_t q_stat,
    input  uigf_pkg::cmd_t        head_cmd,
    output logic                  pop,
    input  logic                  cfg_valid,
    input  logic [15:0]           cfg_data,
    output logic                  result_strobe,
    output uigf_pkg::out_item_t   result
);
    import uigf_pkg::*;

    logic [BYTE_W-1:0]  rx_buffer [BUFFER_DEPTH];

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [THR_W-1:0]   idle_reg, idle_next;
    logic               drop_reg, drop_next;
    logic [THR_W-1:0]   thr_reg;

    logic               res_valid_reg;
    logic               hit_reg, hit_next;
    logic [LEN_W-1:0]   taken_reg, taken_next;
    logic [BYTE_W-1:0]  rd_data_reg;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [THR_W:0]     idle_inc;
    logic [LIMIT_W-1:0] count_ext;
    logic [LIMIT_W-1:0] taken_wide;

    assign pop       = !q_stat.empty;
    assign wr_addr   = count_reg[ADDR_W-1:0];
    assign rd_addr   = ADDR_W'(head_cmd.read_index);
    assign idle_inc  = {1'b0, idle_reg} + 1'b1;
    assign count_ext = LIMIT_W'(count_reg);
    assign taken_wide = (count_ext < head_cmd.read_limit) ? count_ext : head_cmd.read_limit;

    // Event execution
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        idle_next  = idle_reg;
        drop_next  = drop_reg;
        hit_next   = 1'b0;
        taken_next = '0;
        wr_en      = 1'b0;
        if (pop)
        begin
            if (head_cmd.is_byte)
            begin
                if (count_reg < CNT_W'(BUFFER_DEPTH))
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    drop_next = 1'b1;
                end
                phase_next = PH_RECEIVING;
                idle_next  = '0;
            end
            else if (head_cmd.is_tick)
            begin
                if (phase_reg == PH_RECEIVING)
                begin
                    if (idle_inc >= {1'b0, thr_reg})
                    begin
                        idle_next  = '0;
                        phase_next = PH_RECEIVED;
                    end
                    else
                    begin
                        idle_next = idle_inc[THR_W-1:0];
                    end
                end
            end
            else if (head_cmd.is_read)
            begin
                hit_next = (LIMIT_W'(head_cmd.read_index) < count_ext);
            end
            else if (phase_reg == PH_RECEIVED)
            begin
                // successful take
                taken_next = LEN_W'(taken_wide);
                count_next = '0;
                phase_next = PH_IDLE;
                idle_next  = '0;
                drop_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            idle_reg      <= '0;
            drop_reg      <= 1'b0;
            thr_reg       <= THRESHOLD_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            idle_reg      <= idle_next;
            drop_reg      <= drop_next;
            res_valid_reg <= pop;
            if (cfg_valid)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        hit_reg   <= hit_next;
        taken_reg <= taken_next;
    end

    // Frame buffer, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rx_buffer[wr_addr] <= head_cmd.rx_byte;
        end
        rd_data_reg <= rx_buffer[rd_addr];
    end

    assign result_strobe       = res_valid_reg;
    assign result.rx_state     = phase_code(phase_reg);
    assign result.frame_length = LEN_W'(count_reg);
    assign result.read_data    = hit_reg ? rd_data_reg : '0;
    assign result.taken_length = taken_reg;
    assign result.overflow     = drop_reg;

endmodule

### hw/rtl/uart_idle_gap_frame_receiver.sv
// Top level of the idle-gap UART frame receiver.
//
// Usage:
//   Input channel: drive item and raise start; the item transfers at a rising
//   edge with start high and busy low. item.mode selects byte arrival, idle
//   tick, buffer read or frame take.
//   Result channel: each item yields exactly one result, shown on result for
//   one cycle with result_strobe high. The receiver must take it then.
//   Config channel: cfg_data (idle threshold) transfers when cfg_valid and
//   cfg_ready are high; cfg_ready is always high. Write only while idle.
// Timing:
//   A result passes the front holding stage, the command queue and the back end
//   with registered read before it is shown.
//   One item per cycle is sustained; the back end retires one command each
//   cycle and the buffer has one write and one read port.
//   busy rises only when the front stage holds a command and the queue is full.
// Reset (rst_n low, asynchronous): phase idle, frame empty, idle counter and
//   overflow cleared, threshold 20, queue empty. Buffer contents are not cleared.
module uart_idle_gap_frame_receiver (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  uigf_pkg::in_item_t  item,
    output logic                result_strobe,
    output uigf_pkg::out_item_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);
    import uigf_pkg::*;

    queue_stat_t q_stat;
    logic        push;
    logic        pop;
    cmd_t        push_cmd;
    cmd_t        head_cmd;

    assign cfg_ready = 1'b1;

    uigf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item     (item),
        .busy     (busy),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    uigf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    uigf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

### hw/rtl/uigf_checker.sv
// Port-level checker of the idle-gap UART frame receiver, bound to the top level.
`include "uart_idle_gap_frame_receiver_assert.svh"

module uigf_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                result_strobe,
    input uigf_pkg::out_item_t result
);
    import uigf_pkg::*;

    // Reported phase is a defined code
    `UIGF_ASSERT_IMP(a_state_code, result_strobe, (result.rx_state == RX_STATE_IDLE) || (result.rx_state == RX_STATE_RECEIVING) || (result.rx_state == RX_STATE_RECEIVED))

    // A take that hands bytes over leaves an empty idle frame and clears overflow
    `UIGF_ASSERT_IMP(a_take_clears, result_strobe && (result.taken_length != '0), (result.rx_state == RX_STATE_IDLE) && (result.frame_length == '0) && !result.overflow)

    // Nonzero read data only comes from a stored byte
    `UIGF_ASSERT_IMP(a_read_in_frame, result_strobe && (result.read_data != '0), (result.frame_length != '0) && (result.taken_length == '0))

    // Dropped bytes imply a full buffer
    `UIGF_ASSERT_IMP(a_overflow_full, result_strobe && result.overflow, result.frame_length == LEN_W'(BUFFER_DEPTH))

    // Without new transfers the front stage drains and busy stays low
    `UIGF_ASSERT_NXT(a_busy_drains, !busy && !start, !busy)

endmodule

bind uart_idle_gap_frame_receiver uigf_checker u_uigf_checker (.*);
